// ===== hdl/gcsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcsd_pkg: shared types and constants of the cycle-slip detector
// Sizes, operation and register codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gcsd_pkg;

	// sizing
	localparam int NUM_SATS   = 64;
	localparam int COUNT_BITS = 16;
	localparam int SAT_W      = 6;
	localparam int SAT_IDX_W  = (NUM_SATS > 1) ? $clog2(NUM_SATS) : 1;
	localparam int TIME_W     = 40;
	// signed numerator count*mean + mw, its magnitude, and the divisor count+1
	localparam int NUM_W      = COUNT_BITS + 33;
	localparam int MAG_W      = COUNT_BITS + 32;
	localparam int DEN_W      = COUNT_BITS + 1;
	localparam int ITER_W     = $clog2(MAG_W);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// register indexes
	localparam logic [1:0] CFG_IDX_INTERVAL = 2'd0;
	localparam logic [1:0] CFG_IDX_MW_LIMIT = 2'd1;
	localparam logic [1:0] CFG_IDX_GF_LIMIT = 2'd2;

	// register reset values
	localparam logic [31:0] INTERVAL_RST = 32'd1000;
	localparam logic [30:0] MW_LIMIT_RST = 31'd65536;
	localparam logic [30:0] GF_LIMIT_RST = 31'd3277;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_OBS   = 2'd1,
		OP_END   = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_ADD,
		ST_DIVS,
		ST_DIVW,
		ST_MEAN,
		ST_UPD,
		ST_FIN
	} state_t;

	// per-satellite history entry
	typedef struct packed {
		logic [COUNT_BITS-1:0] cnt;
		logic signed [31:0]    mean;
		logic signed [31:0]    gf;
	} ent_t;

	// controller to datapath
	typedef struct packed {
		logic cap;
		logic do_start;
		logic do_end;
		logic do_null;
		logic mem_rd;
		logic do_short;
		logic do_mul;
		logic do_add;
		logic div_start;
		logic do_mean;
		logic do_upd;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic sat_ok;
		logic gap;
		logic dual;
		logic div_done;
		logic out_free;
	} sts_t;

	// zero-extend a satellite slot to the table index width
	function automatic logic [SAT_IDX_W-1:0] sat_to_idx(input logic [SAT_W-1:0] s);
		logic [SAT_IDX_W+SAT_W-1:0] w;
		w = {{SAT_IDX_W{1'b0}}, s};
		return w[SAT_IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/gcsd_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcsd_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle over the MAG_W bits of the dividend.
// done pulses in the cycle after the last step, with the quotient valid.
// ----------------------------------------------------------------------------
module gcsd_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [gcsd_pkg::MAG_W-1:0]   dividend,
	input  wire logic [gcsd_pkg::DEN_W-1:0]   divisor,
	output logic                              done,
	output logic [gcsd_pkg::MAG_W-1:0]        quotient
);

	logic                             busy_q;
	logic                             done_q;
	logic [gcsd_pkg::ITER_W-1:0]      iter_q;
	logic [gcsd_pkg::MAG_W-1:0]       quo_q;
	logic [gcsd_pkg::DEN_W:0]         rem_q;
	logic [gcsd_pkg::DEN_W-1:0]       den_q;

	logic [gcsd_pkg::DEN_W:0]         rem_sh;
	logic [gcsd_pkg::DEN_W+1:0]       diff;
	logic                             ge;

	// one restoring step
	always_comb begin
		rem_sh = {rem_q[gcsd_pkg::DEN_W-1:0], quo_q[gcsd_pkg::MAG_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, den_q};
		ge     = ~diff[gcsd_pkg::DEN_W+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= busy_q && !start && (iter_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= gcsd_pkg::ITER_W'(gcsd_pkg::MAG_W - 1);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[gcsd_pkg::MAG_W-2:0], ge};
			rem_q <= ge ? diff[gcsd_pkg::DEN_W:0] : rem_sh;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while still iterating");

endmodule
`default_nettype wire

// ===== hdl/gcsd_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcsd_datapath: registers, satellite history table and arithmetic
// Holds configuration, epoch state, the per-satellite table with its valid
// and seen bits, the mean update with its divider, and the output register.
// ----------------------------------------------------------------------------
module gcsd_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire gcsd_pkg::cmd_t       cmd,
	output gcsd_pkg::sts_t            sts,
	// input payload
	input  wire logic [1:0]           operation,
	input  wire logic [39:0]          epoch_time_ms,
	input  wire logic [5:0]           sat_index,
	input  wire logic                 dual_freq,
	input  wire logic signed [31:0]   mw_value,
	input  wire logic signed [31:0]   gf_value,
	// configuration
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [31:0]          cfg_data,
	// result
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      epoch_gap,
	output logic                      keep_observation,
	output logic                      is_outlier,
	output logic [15:0]               clean_count_out,
	output logic signed [31:0]        mw_mean_out
);

	localparam int N = gcsd_pkg::NUM_SATS;
	localparam int C = gcsd_pkg::COUNT_BITS;

	// captured item
	logic [1:0]                       op_q;
	logic [gcsd_pkg::TIME_W-1:0]      time_q;
	logic [gcsd_pkg::SAT_W-1:0]       sat_q;
	logic                             dual_q;
	logic signed [31:0]               mwv_q;
	logic signed [31:0]               gfv_q;

	// configuration and epoch state
	logic [31:0]                      interval_q;
	logic [30:0]                      mw_limit_q;
	logic [30:0]                      gf_limit_q;
	logic [gcsd_pkg::TIME_W-1:0]      last_time_q;
	logic                             gap_q;

	// satellite table
	gcsd_pkg::ent_t                   mem [N];
	gcsd_pkg::ent_t                   rd_q;
	logic [N-1:0]                     cnt_vld_q;
	logic [N-1:0]                     ent_vld_q;
	logic [N-1:0]                     seen_q;

	// arithmetic
	logic signed [gcsd_pkg::NUM_W-1:0] prod_q;
	logic signed [gcsd_pkg::NUM_W-1:0] num_q;
	logic signed [31:0]                mean_q;
	logic                              div_done;
	logic [gcsd_pkg::MAG_W-1:0]        quo;

	// staged result
	logic                             res_keep_q;
	logic                             res_outl_q;
	logic [C-1:0]                     res_cnt_q;
	logic signed [31:0]               res_mean_q;

	// output register
	logic                             out_valid_q;
	logic                             out_gap_q;
	logic                             out_keep_q;
	logic                             out_outl_q;
	logic [15:0]                      out_cnt_q;
	logic signed [31:0]               out_mean_q;

	logic [gcsd_pkg::SAT_IDX_W-1:0]   idx;
	logic                             sat_ok;
	logic [C-1:0]                     cur_cnt;
	logic signed [31:0]               cur_mean;
	logic signed [31:0]               cur_gf;
	logic [gcsd_pkg::TIME_W-1:0]      tdiff;
	logic                             gap_new;
	logic [gcsd_pkg::NUM_W-1:0]       num_mag;
	logic [gcsd_pkg::DEN_W-1:0]       den;
	logic [31:0]                      q32;
	logic [32:0]                      dmw;
	logic [32:0]                      dgf;
	logic [32:0]                      amw;
	logic [32:0]                      agf;
	logic                             outl;
	logic [C-1:0]                     cnt_new;
	logic                             out_free;

	// decode and table read
	always_comb begin
		idx      = gcsd_pkg::sat_to_idx(sat_q);
		sat_ok   = ({3'b000, sat_q} < 9'(N));
		cur_cnt  = cnt_vld_q[idx] ? rd_q.cnt  : '0;
		cur_mean = ent_vld_q[idx] ? rd_q.mean : '0;
		cur_gf   = ent_vld_q[idx] ? rd_q.gf   : '0;
	end

	// epoch continuity
	always_comb begin
		tdiff   = time_q - last_time_q;
		gap_new = (time_q >= last_time_q) && (tdiff > {8'h00, interval_q});
	end

	// divider operands: magnitude of the numerator, count + 1
	always_comb begin
		num_mag = num_q[gcsd_pkg::NUM_W-1] ? (gcsd_pkg::NUM_W'(0) - num_q) : num_q;
		den     = {1'b0, cur_cnt} + gcsd_pkg::DEN_W'(1);
		q32     = quo[31:0];
	end

	// outlier test and count update
	always_comb begin
		dmw = {mean_q[31], mean_q} - {cur_mean[31], cur_mean};
		dgf = {gfv_q[31], gfv_q} - {cur_gf[31], cur_gf};
		amw = dmw[32] ? (33'd0 - dmw) : dmw;
		agf = dgf[32] ? (33'd0 - dgf) : dgf;
		outl = (cur_cnt == '0) || (amw > {2'b00, mw_limit_q}) || (agf > {2'b00, gf_limit_q});
		if (cur_cnt == '0) begin
			cnt_new = C'(1);
		end else if (outl) begin
			cnt_new = '0;
		end else if (cur_cnt < gcsd_pkg::CNT_MAX) begin
			cnt_new = cur_cnt + 1'b1;
		end else begin
			cnt_new = cur_cnt;
		end
	end

	gcsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num_mag[gcsd_pkg::MAG_W-1:0]),
		.divisor  (den),
		.done     (div_done),
		.quotient (quo)
	);

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= operation;
			time_q <= epoch_time_ms;
			sat_q  <= sat_index;
			dual_q <= dual_freq;
			mwv_q  <= mw_value;
			gfv_q  <= gf_value;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= gcsd_pkg::INTERVAL_RST;
			mw_limit_q <= gcsd_pkg::MW_LIMIT_RST;
			gf_limit_q <= gcsd_pkg::GF_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				gcsd_pkg::CFG_IDX_INTERVAL: interval_q <= cfg_data;
				gcsd_pkg::CFG_IDX_MW_LIMIT: mw_limit_q <= cfg_data[30:0];
				gcsd_pkg::CFG_IDX_GF_LIMIT: gf_limit_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// epoch state, valid and seen bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			gap_q       <= 1'b0;
			cnt_vld_q   <= '0;
			ent_vld_q   <= '0;
			seen_q      <= '0;
		end else if (cmd.do_start) begin
			last_time_q <= time_q;
			gap_q       <= gap_new;
			seen_q      <= '0;
		end else if (cmd.do_end) begin
			if (!gap_q) begin
				cnt_vld_q <= cnt_vld_q & seen_q;
			end
			seen_q <= '0;
		end else if (cmd.do_short) begin
			if (!gap_q) begin
				seen_q[idx] <= 1'b1;
			end
		end else if (cmd.do_upd) begin
			seen_q[idx]    <= 1'b1;
			cnt_vld_q[idx] <= 1'b1;
			ent_vld_q[idx] <= 1'b1;
		end
	end

	// satellite table, registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_q <= mem[idx];
		end
		if (cmd.do_upd) begin
			mem[idx] <= '{cnt: cnt_new, mean: mean_q, gf: gfv_q};
		end
	end

	// mean update pipeline and staged result
	always_ff @(posedge clk) begin
		if (cmd.do_mul) begin
			prod_q <= $signed({1'b0, cur_cnt}) * cur_mean;
		end
		if (cmd.do_add) begin
			num_q <= prod_q + gcsd_pkg::NUM_W'(mwv_q);
		end
		if (cmd.do_mean) begin
			mean_q <= num_q[gcsd_pkg::NUM_W-1] ? (32'd0 - q32) : q32;
		end
		if (cmd.do_start || cmd.do_end || cmd.do_null) begin
			res_keep_q <= 1'b0;
			res_outl_q <= 1'b0;
			res_cnt_q  <= '0;
			res_mean_q <= '0;
		end else if (cmd.do_short) begin
			res_keep_q <= 1'b0;
			res_outl_q <= 1'b0;
			res_cnt_q  <= cur_cnt;
			res_mean_q <= cur_mean;
		end else if (cmd.do_upd) begin
			res_keep_q <= ~outl;
			res_outl_q <= outl;
			res_cnt_q  <= cnt_new;
			res_mean_q <= mean_q;
		end
	end

	// output register
	assign out_free = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_gap_q  <= gap_q;
			out_keep_q <= res_keep_q;
			out_outl_q <= res_outl_q;
			out_cnt_q  <= 16'(res_cnt_q);
			out_mean_q <= res_mean_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign epoch_gap        = out_gap_q;
	assign keep_observation = out_keep_q;
	assign is_outlier       = out_outl_q;
	assign clean_count_out  = out_cnt_q;
	assign mw_mean_out      = out_mean_q;

	// status
	always_comb begin
		sts.op       = gcsd_pkg::op_t'(op_q);
		sts.sat_ok   = sat_ok;
		sts.gap      = gap_q;
		sts.dual     = dual_q;
		sts.div_done = div_done;
		sts.out_free = out_free;
	end

endmodule
`default_nettype wire

// ===== hdl/gcsd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcsd_ctrl: sequencer of the cycle-slip detector
// One item at a time: decode; for an in-range observation, table read and, if
// dual and gap-free, multiply, add, divide, mean and update; then hand-over.
// ----------------------------------------------------------------------------
module gcsd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire gcsd_pkg::sts_t   sts,
	output gcsd_pkg::cmd_t        cmd
);

	gcsd_pkg::state_t state_q;
	gcsd_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcsd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			gcsd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = gcsd_pkg::ST_DECODE;
				end
			end
			gcsd_pkg::ST_DECODE: begin
				state_d = gcsd_pkg::ST_FIN;
				case (sts.op)
					gcsd_pkg::OP_START: cmd.do_start = 1'b1;
					gcsd_pkg::OP_END:   cmd.do_end = 1'b1;
					gcsd_pkg::OP_OBS: begin
						if (sts.sat_ok) begin
							cmd.mem_rd = 1'b1;
							state_d    = gcsd_pkg::ST_READ;
						end else begin
							cmd.do_null = 1'b1;
						end
					end
					default: cmd.do_null = 1'b1;
				endcase
			end
			gcsd_pkg::ST_READ: begin
				// gap epoch or single frequency: report history only
				if (sts.gap || !sts.dual) begin
					cmd.do_short = 1'b1;
					state_d      = gcsd_pkg::ST_FIN;
				end else begin
					cmd.do_mul = 1'b1;
					state_d    = gcsd_pkg::ST_ADD;
				end
			end
			gcsd_pkg::ST_ADD: begin
				cmd.do_add = 1'b1;
				state_d    = gcsd_pkg::ST_DIVS;
			end
			gcsd_pkg::ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = gcsd_pkg::ST_DIVW;
			end
			gcsd_pkg::ST_DIVW: begin
				if (sts.div_done) begin
					state_d = gcsd_pkg::ST_MEAN;
				end
			end
			gcsd_pkg::ST_MEAN: begin
				cmd.do_mean = 1'b1;
				state_d     = gcsd_pkg::ST_UPD;
			end
			gcsd_pkg::ST_UPD: begin
				cmd.do_upd = 1'b1;
				state_d    = gcsd_pkg::ST_FIN;
			end
			gcsd_pkg::ST_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = gcsd_pkg::ST_IDLE;
				end
			end
			default: state_d = gcsd_pkg::ST_IDLE;
		endcase
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free) else $error("result loaded over a pending one");
	a_cap_decode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |=> state_q == gcsd_pkg::ST_DECODE) else $error("captured item not decoded");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done && state_q == gcsd_pkg::ST_DIVW)
		else $error("divide not awaited");

endmodule
`default_nettype wire

// ===== hdl/gnss_cycle_slip_detector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gnss_cycle_slip_detector: MW/GF cycle-slip and outlier screen
// Input channel (in_valid/in_stall) carries epoch-start, observation and
// epoch-end items; every item gives exactly one result transaction on the
// output channel (out_valid/out_stall). Registers are written through the
// cfg channel (cfg_valid/cfg_ready, always ready); the user must write them
// only while the block is idle; the block does not enforce this. One item
// is processed at a time. A dual-frequency observation in a continuous
// epoch goes through the bit-serial divider for the MW running mean, one
// quotient bit per cycle. Epoch items, ignored items and single-frequency
// or gap-epoch observations skip the divider. The result sits in an output
// register, so a stalled result does not block acceptance of the next item;
// a further result waits inside until the output register is free.
// Reset clears epoch state and the per-satellite valid and seen bits at
// once; the history table needs no clearing pass and the block accepts
// items straight out of reset.
// ----------------------------------------------------------------------------
module gnss_cycle_slip_detector (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// item input
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           operation,
	input  wire logic [39:0]          epoch_time_ms,
	input  wire logic [5:0]           sat_index,
	input  wire logic                 dual_freq,
	input  wire logic signed [31:0]   mw_value,
	input  wire logic signed [31:0]   gf_value,
	// configuration
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [31:0]          cfg_data,
	// result output
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      epoch_gap,
	output logic                      keep_observation,
	output logic                      is_outlier,
	output logic [15:0]               clean_count_out,
	output logic signed [31:0]        mw_mean_out
);

	gcsd_pkg::cmd_t cmd;
	gcsd_pkg::sts_t sts;

	gcsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	gcsd_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.operation        (operation),
		.epoch_time_ms    (epoch_time_ms),
		.sat_index        (sat_index),
		.dual_freq        (dual_freq),
		.mw_value         (mw_value),
		.gf_value         (gf_value),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.epoch_gap        (epoch_gap),
		.keep_observation (keep_observation),
		.is_outlier       (is_outlier),
		.clean_count_out  (clean_count_out),
		.mw_mean_out      (mw_mean_out)
	);

endmodule
`default_nettype wire
